// File: hdl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define RSTK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define RSTK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rstk_pkg.sv
// Shared constants and codes for the recency stack tracker.
package rstk_pkg;

    localparam int DEPTH     = 16;
    localparam int ID_BITS   = 8;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int REQ_W     = 3;
    localparam int PORT_ID_W = 8;
    localparam int RANK_W    = 5;
    localparam int COUNT_W   = 5;
    localparam int RANK_MAX  = 15;
    localparam int COUNT_SAT = 31;

    localparam logic signed [RANK_W-1:0] RANK_NONE = -5'sd1;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 3'd0,
        REQ_FORCE  = 3'd1,
        REQ_QUERY  = 3'd2,
        REQ_POP    = 3'd3,
        REQ_REMOVE = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

// File: hdl/recency_stack_tracker.sv
// Move-to-front recency stack of distinct identifiers held in one synchronous RAM.
//
// Each request beat (push, force to top, query rank, pop, remove) yields exactly one
// result beat carrying hit_or_done, rank, top_id, entry_count and status. Stack
// position 0 of the RAM is the bottom, position count-1 the top. The RAM has one
// read port and one write port, and its registered read paces the block:
// a lookup streams the positions bottom-up, one per cycle, and stops at the match
// or after the last held entry; a removal from the middle (remove, or force of a
// present identifier) then copies every entry above the gap down by one, again one
// per cycle, and a force then writes the identifier on top. A final read fetches
// the top identifier (for a pop, the entry it removed). One item is worked on at
// a time; in_stall is high while it is in flight, also while it waits for the
// previous result to leave under out_stall. A finished result sits in an output
// register, so the next request can be taken while the previous result still
// waits on out_stall. A push or a force of a new identifier onto a full stack
// changes nothing and reports full status; a pop of an empty stack reports empty
// status with top_id 0.
module recency_stack_tracker
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [rstk_pkg::REQ_W-1:0]          req_type,
    input  logic [rstk_pkg::PORT_ID_W-1:0]      entry_id,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit_or_done,
    output logic signed [rstk_pkg::RANK_W-1:0]  rank,
    output logic [rstk_pkg::PORT_ID_W-1:0]      top_id,
    output logic [rstk_pkg::COUNT_W-1:0]        entry_count,
    output logic [1:0]                          status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_FORCE_W,
        S_TOP,
        S_OUT
    } state_t;

    // stack storage, bottom at address 0
    logic [rstk_pkg::ID_BITS-1:0] stack_mem [rstk_pkg::DEPTH];
    logic [rstk_pkg::ID_BITS-1:0] rd_data_reg;

    logic                         mem_we;
    logic [rstk_pkg::PTR_W-1:0]   mem_wa;
    logic [rstk_pkg::ID_BITS-1:0] mem_wd;
    logic                         mem_re;
    logic [rstk_pkg::PTR_W-1:0]   mem_ra;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= stack_mem[mem_ra];
        end
    end

    // control and result registers
    state_t                            state_reg,       state_next;
    logic [rstk_pkg::CNT_W-1:0]        count_reg,       count_next;
    logic [rstk_pkg::REQ_W-1:0]        req_reg,         req_next;
    logic [rstk_pkg::ID_BITS-1:0]      id_reg,          id_next;
    logic [rstk_pkg::PTR_W-1:0]        ptr_reg,         ptr_next;
    logic                              found_reg,       found_next;
    logic [rstk_pkg::PTR_W-1:0]        pos_reg,         pos_next;
    logic                              hit_reg,         hit_next;
    logic signed [rstk_pkg::RANK_W-1:0] rank_reg,       rank_next;
    rstk_pkg::status_t                 status_reg,      status_next;
    logic                              top_zero_reg,    top_zero_next;

    logic                              out_valid_reg,   out_valid_next;
    logic                              out_hit_reg,     out_hit_next;
    logic signed [rstk_pkg::RANK_W-1:0] out_rank_reg,   out_rank_next;
    logic [rstk_pkg::PORT_ID_W-1:0]    out_top_reg,     out_top_next;
    logic [rstk_pkg::COUNT_W-1:0]      out_count_reg,   out_count_next;
    rstk_pkg::status_t                 out_status_reg,  out_status_next;

    logic                              accept;
    logic                              needs_scan;
    logic                              scan_match;
    logic [rstk_pkg::CNT_W-1:0]        count_m1;
    logic [rstk_pkg::CNT_W-1:0]        count_m2;
    logic [rstk_pkg::CNT_W-1:0]        rank_calc;
    logic                              pos_is_top;
    logic                              stack_full;

    assign accept     = in_valid && (state_reg == S_IDLE);
    assign needs_scan = (req_type == rstk_pkg::REQ_PUSH)  || (req_type == rstk_pkg::REQ_FORCE) ||
                        (req_type == rstk_pkg::REQ_QUERY) || (req_type == rstk_pkg::REQ_REMOVE);
    assign count_m1   = count_reg - rstk_pkg::CNT_W'(1);
    assign count_m2   = count_reg - rstk_pkg::CNT_W'(2);
    assign scan_match = (rd_data_reg == id_reg);
    assign rank_calc  = count_m1 - rstk_pkg::CNT_W'(pos_reg);
    assign pos_is_top = (rstk_pkg::CNT_W'(pos_reg) == count_m1);
    assign stack_full = (count_reg == rstk_pkg::CNT_W'(rstk_pkg::DEPTH));

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        req_next        = req_reg;
        id_next         = id_reg;
        ptr_next        = ptr_reg;
        found_next      = found_reg;
        pos_next        = pos_reg;
        hit_next        = hit_reg;
        rank_next       = rank_reg;
        status_next     = status_reg;
        top_zero_next   = top_zero_reg;

        out_valid_next  = out_valid_reg && out_stall;
        out_hit_next    = out_hit_reg;
        out_rank_next   = out_rank_reg;
        out_top_next    = out_top_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;

        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = id_reg;
        mem_re = 1'b0;
        mem_ra = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next    = req_type;
                    id_next     = entry_id[rstk_pkg::ID_BITS-1:0];
                    found_next  = 1'b0;
                    pos_next    = '0;
                    hit_next    = 1'b0;
                    rank_next   = rstk_pkg::RANK_NONE;
                    status_next = rstk_pkg::ST_OK;
                    ptr_next    = '0;
                    if (needs_scan && (count_reg != '0))
                    begin
                        // first lookup read: bottom entry
                        mem_re     = 1'b1;
                        mem_ra     = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_SCAN:
            begin
                // rd_data_reg holds the entry at ptr_reg; prefetch the next one
                if (scan_match)
                begin
                    found_next = 1'b1;
                    pos_next   = ptr_reg;
                    state_next = S_DECIDE;
                end
                else if (rstk_pkg::CNT_W'(ptr_reg) == count_m1)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    mem_re   = 1'b1;
                    mem_ra   = ptr_reg + rstk_pkg::PTR_W'(1);
                    ptr_next = ptr_reg + rstk_pkg::PTR_W'(1);
                end
            end

            S_DECIDE:
            begin
                state_next = S_TOP;
                case (req_reg)
                    rstk_pkg::REQ_PUSH,
                    rstk_pkg::REQ_FORCE:
                    begin
                        if (!found_reg)
                        begin
                            if (stack_full)
                            begin
                                status_next = rstk_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_wa     = rstk_pkg::PTR_W'(count_reg);
                                count_next = count_reg + rstk_pkg::CNT_W'(1);
                                hit_next   = 1'b1;
                            end
                        end
                        else if ((req_reg == rstk_pkg::REQ_FORCE) && !pos_is_top)
                        begin
                            mem_re     = 1'b1;
                            mem_ra     = pos_reg + rstk_pkg::PTR_W'(1);
                            ptr_next   = pos_reg;
                            state_next = S_SHIFT;
                        end
                    end
                    rstk_pkg::REQ_QUERY:
                    begin
                        if (found_reg)
                        begin
                            hit_next = 1'b1;
                            if (int'(rank_calc) > rstk_pkg::RANK_MAX)
                            begin
                                rank_next = rstk_pkg::RANK_W'(rstk_pkg::RANK_MAX);
                            end
                            else
                            begin
                                rank_next = $signed(rstk_pkg::RANK_W'(rank_calc));
                            end
                        end
                    end
                    rstk_pkg::REQ_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = rstk_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_m1;
                        end
                    end
                    rstk_pkg::REQ_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            hit_next = 1'b1;
                            if (pos_is_top)
                            begin
                                count_next = count_m1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_ra     = pos_reg + rstk_pkg::PTR_W'(1);
                                ptr_next   = pos_reg;
                                state_next = S_SHIFT;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_SHIFT:
            begin
                // rd_data_reg holds entry ptr_reg+1; move it down one slot
                mem_we = 1'b1;
                mem_wa = ptr_reg;
                mem_wd = rd_data_reg;
                if (rstk_pkg::CNT_W'(ptr_reg) == count_m2)
                begin
                    if (req_reg == rstk_pkg::REQ_FORCE)
                    begin
                        state_next = S_FORCE_W;
                    end
                    else
                    begin
                        count_next = count_m1;
                        state_next = S_TOP;
                    end
                end
                else
                begin
                    mem_re   = 1'b1;
                    mem_ra   = ptr_reg + rstk_pkg::PTR_W'(2);
                    ptr_next = ptr_reg + rstk_pkg::PTR_W'(1);
                end
            end

            S_FORCE_W:
            begin
                mem_we     = 1'b1;
                mem_wa     = rstk_pkg::PTR_W'(count_m1);
                state_next = S_TOP;
            end

            S_TOP:
            begin
                // a pop reports the entry it removed, which sits at the new count
                mem_re = 1'b1;
                if (req_reg == rstk_pkg::REQ_POP)
                begin
                    mem_ra        = rstk_pkg::PTR_W'(count_reg);
                    top_zero_next = (status_reg == rstk_pkg::ST_EMPTY);
                end
                else
                begin
                    mem_ra        = rstk_pkg::PTR_W'(count_m1);
                    top_zero_next = (count_reg == '0);
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_hit_next    = hit_reg;
                    out_rank_next   = rank_reg;
                    out_status_next = status_reg;
                    out_top_next    = top_zero_reg ? '0 : rstk_pkg::PORT_ID_W'(rd_data_reg);
                    if (int'(count_reg) > rstk_pkg::COUNT_SAT)
                    begin
                        out_count_next = rstk_pkg::COUNT_W'(rstk_pkg::COUNT_SAT);
                    end
                    else
                    begin
                        out_count_next = rstk_pkg::COUNT_W'(count_reg);
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            req_reg        <= '0;
            id_reg         <= '0;
            ptr_reg        <= '0;
            found_reg      <= 1'b0;
            pos_reg        <= '0;
            hit_reg        <= 1'b0;
            rank_reg       <= rstk_pkg::RANK_NONE;
            status_reg     <= rstk_pkg::ST_OK;
            top_zero_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
            out_hit_reg    <= 1'b0;
            out_rank_reg   <= rstk_pkg::RANK_NONE;
            out_top_reg    <= '0;
            out_count_reg  <= '0;
            out_status_reg <= rstk_pkg::ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            req_reg        <= req_next;
            id_reg         <= id_next;
            ptr_reg        <= ptr_next;
            found_reg      <= found_next;
            pos_reg        <= pos_next;
            hit_reg        <= hit_next;
            rank_reg       <= rank_next;
            status_reg     <= status_next;
            top_zero_reg   <= top_zero_next;
            out_valid_reg  <= out_valid_next;
            out_hit_reg    <= out_hit_next;
            out_rank_reg   <= out_rank_next;
            out_top_reg    <= out_top_next;
            out_count_reg  <= out_count_next;
            out_status_reg <= out_status_next;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign hit_or_done = out_hit_reg;
    assign rank        = out_rank_reg;
    assign top_id      = out_top_reg;
    assign entry_count = out_count_reg;
    assign status      = out_status_reg;

endmodule

// File: hdl/rstk_checker.sv
// Port-level assertions for the recency stack tracker, bound to the top level.
`include "assert_macros.svh"

module rstk_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [rstk_pkg::REQ_W-1:0]          req_type,
    input  logic [rstk_pkg::PORT_ID_W-1:0]      entry_id,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                hit_or_done,
    input  logic signed [rstk_pkg::RANK_W-1:0]  rank,
    input  logic [rstk_pkg::PORT_ID_W-1:0]      top_id,
    input  logic [rstk_pkg::COUNT_W-1:0]        entry_count,
    input  logic [1:0]                          status
);

    localparam int OUT_W = 1 + rstk_pkg::RANK_W + rstk_pkg::PORT_ID_W + rstk_pkg::COUNT_W + 2;

    logic                                            in_held;
    logic                                            out_held;
    logic [rstk_pkg::REQ_W+rstk_pkg::PORT_ID_W-1:0]  in_word;
    logic [OUT_W-1:0]                                out_word;
    logic                                            is_empty;
    logic                                            is_full;
    logic                                            empty_ok;
    logic                                            full_ok;

    assign in_held  = in_valid && in_stall;
    assign out_held = out_valid && out_stall;
    assign in_word  = {req_type, entry_id};
    assign out_word = {hit_or_done, rank, top_id, entry_count, status};
    assign is_empty = out_valid && (status == rstk_pkg::ST_EMPTY);
    assign is_full  = out_valid && (status == rstk_pkg::ST_FULL);
    assign empty_ok = (entry_count == '0) && (top_id == '0) && !hit_or_done;
    assign full_ok  = !hit_or_done && (rank == rstk_pkg::RANK_NONE) && (entry_count != '0);

    // a stalled result beat holds
    `RSTK_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_word), "result not held")

    // occupancy never goes past the stack depth
    `RSTK_ASSERT_NOW(a_count_bound, out_valid, int'(entry_count) <= rstk_pkg::DEPTH, "count > depth")

    // an empty pop leaves nothing behind
    `RSTK_ASSERT_NOW(a_empty_pop, is_empty, empty_ok, "empty status with stack contents")

    // a refused insert is never reported as done and carries no rank
    `RSTK_ASSERT_NOW(a_full_refuse, is_full, full_ok, "full status with insert done")

    // a stalled request beat holds
    `RSTK_ASSERT_NEXT(a_in_hold, in_held, in_valid && $stable(in_word), "request not held")

endmodule

bind recency_stack_tracker rstk_checker u_rstk_checker (.*);
